// File: design/rotation_matrix_to_quaternion_macros.svh
// assertion macros for the rotation matrix to quaternion block
// expects clk and rst_n in the scope of the module that uses them
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// consequent checked in the same cycle
`define RMQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmq check failed");

// consequent checked in the cycle after the antecedent
`define RMQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmq check failed");

`endif

// File: design/rmq_pkg.sv
// shared types, widths and helpers for the rotation matrix to quaternion block
// no dependencies
`default_nettype none

package rmq_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int ZT_W      = 16;
    localparam int ONE       = 1 << FRAC_BITS;

    // radicand, square root and divider widths
    localparam int RAD_W   = 34;
    localparam int SQ_IN_W = RAD_W + FRAC_BITS;
    localparam int ROOT_W  = (SQ_IN_W + 1) / 2;
    localparam int XW      = 2 * ROOT_W;
    localparam int MAG_W   = DATA_W + 1;
    localparam int DEN_W   = ROOT_W + 1;
    localparam int DREM_W  = DEN_W + 1;
    localparam int QUO_W   = DATA_W - 1;
    localparam int DVD_W   = MAG_W + FRAC_BITS;
    localparam int SAT_SH  = QUO_W - FRAC_BITS;
    localparam int CMP_W   = DEN_W + SAT_SH + 1;

    // apb
    localparam int ADDR_W  = 2;
    localparam int PDATA_W = 32;
    localparam logic [ADDR_W-1:0] ZT_ADDR = 2'd0;

    // quaternion slots; the axis code uses the first three
    localparam logic [1:0] SLOT_X = 2'd0;
    localparam logic [1:0] SLOT_Y = 2'd1;
    localparam logic [1:0] SLOT_Z = 2'd2;
    localparam logic [1:0] SLOT_W = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] m00;
        logic signed [DATA_W-1:0] m01;
        logic signed [DATA_W-1:0] m02;
        logic signed [DATA_W-1:0] m03;
        logic signed [DATA_W-1:0] m10;
        logic signed [DATA_W-1:0] m11;
        logic signed [DATA_W-1:0] m12;
        logic signed [DATA_W-1:0] m13;
        logic signed [DATA_W-1:0] m20;
        logic signed [DATA_W-1:0] m21;
        logic signed [DATA_W-1:0] m22;
        logic signed [DATA_W-1:0] m23;
    } rmq_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] quat_x;
        logic signed [DATA_W-1:0] quat_y;
        logic signed [DATA_W-1:0] quat_z;
        logic signed [DATA_W-1:0] quat_w;
        logic                     degenerate;
    } rmq_out_t;

    // travels alongside the square root
    typedef struct packed {
        logic                       degen;
        logic [1:0]                 sel;
        logic [2:0]                 neg;
        logic [2:0][MAG_W-1:0]      mag;
    } rmq_side_t;

    // travels alongside the dividers
    typedef struct packed {
        logic                       degen;
        logic [1:0]                 sel;
        logic [2:0]                 neg;
        logic [ROOT_W-2:0]          half;
    } rmq_qside_t;

    typedef struct packed {
        rmq_qside_t                 side;
        logic [2:0]                 sat;
        logic [2:0][QUO_W-1:0]      quo;
    } rmq_quo_t;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [MAG_W-1:0] v);
        return (v < 0) ? MAG_W'(-v) : MAG_W'(v);
    endfunction

endpackage

`default_nettype wire

// File: design/rmq_front.sv
// front stages: near-zero row test, trace, axis pick, radicand and numerators
// depends on rmq_pkg
`default_nettype none

module rmq_front
    import rmq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  rmq_in_t             mat,
    input  logic [ZT_W-1:0]     zero_thr,
    output logic                out_valid,
    output logic [RAD_W-1:0]    rad,
    output rmq_side_t           side
);

    logic signed [DATA_W-1:0] mv [3][4];
    logic [2:0]               row_small;
    logic signed [RAD_W:0]    tr_s;
    logic [1:0]               axis_s;

    // stage a
    logic                     a_valid_reg;
    logic                     a_degen_reg;
    logic signed [RAD_W:0]    a_tr_reg;
    logic [1:0]               a_axis_reg;
    logic signed [DATA_W-1:0] a_m_reg [3][3];

    // stage b
    logic                     b_valid_reg;
    logic [RAD_W-1:0]         b_rad_reg;
    rmq_side_t                b_side_reg;
    logic signed [RAD_W:0]    rad_next;
    rmq_side_t                side_next;

    always_comb
    begin
        mv[0][0] = mat.m00; mv[0][1] = mat.m01; mv[0][2] = mat.m02; mv[0][3] = mat.m03;
        mv[1][0] = mat.m10; mv[1][1] = mat.m11; mv[1][2] = mat.m12; mv[1][3] = mat.m13;
        mv[2][0] = mat.m20; mv[2][1] = mat.m21; mv[2][2] = mat.m22; mv[2][3] = mat.m23;
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_small[r] = 1'b1;
            for (int c = 0; c < 4; c++)
            begin
                if (mag_of(MAG_W'(mv[r][c])) > MAG_W'(zero_thr))
                begin
                    row_small[r] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        logic                     y_wins;
        logic signed [DATA_W-1:0] dmax;
        y_wins = mat.m11 > mat.m00;
        dmax   = y_wins ? mat.m11 : mat.m00;
        tr_s   = (RAD_W+1)'(mat.m00) + (RAD_W+1)'(mat.m11) + (RAD_W+1)'(mat.m22);
        if (mat.m22 > dmax)
        begin
            axis_s = SLOT_Z;
        end
        else
        begin
            axis_s = y_wins ? SLOT_Y : SLOT_X;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_degen_reg <= |row_small;
            a_tr_reg    <= tr_s;
            a_axis_reg  <= axis_s;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    a_m_reg[r][c] <= mv[r][c];
                end
            end
        end
    end

    // stage b: pick radicand and the three numerators
    always_comb
    begin
        logic signed [RAD_W:0]    e00;
        logic signed [RAD_W:0]    e11;
        logic signed [RAD_W:0]    e22;
        logic signed [RAD_W:0]    one_r;
        logic signed [MAG_W-1:0]  n [3];
        e00   = (RAD_W+1)'(a_m_reg[0][0]);
        e11   = (RAD_W+1)'(a_m_reg[1][1]);
        e22   = (RAD_W+1)'(a_m_reg[2][2]);
        one_r = (RAD_W+1)'(ONE);
        side_next.degen = a_degen_reg;
        if (a_tr_reg > 0)
        begin
            rad_next       = a_tr_reg + one_r;
            side_next.sel  = SLOT_W;
            n[0] = MAG_W'(a_m_reg[1][2]) - MAG_W'(a_m_reg[2][1]);
            n[1] = MAG_W'(a_m_reg[2][0]) - MAG_W'(a_m_reg[0][2]);
            n[2] = MAG_W'(a_m_reg[0][1]) - MAG_W'(a_m_reg[1][0]);
        end
        else
        begin
            case (a_axis_reg)
                SLOT_Y:
                begin
                    rad_next      = e11 - e22 - e00 + one_r;
                    side_next.sel = SLOT_Y;
                    n[0] = MAG_W'(a_m_reg[1][0]) + MAG_W'(a_m_reg[0][1]);
                    n[1] = MAG_W'(a_m_reg[1][2]) + MAG_W'(a_m_reg[2][1]);
                    n[2] = MAG_W'(a_m_reg[2][0]) - MAG_W'(a_m_reg[0][2]);
                end
                SLOT_Z:
                begin
                    rad_next      = e22 - e00 - e11 + one_r;
                    side_next.sel = SLOT_Z;
                    n[0] = MAG_W'(a_m_reg[2][0]) + MAG_W'(a_m_reg[0][2]);
                    n[1] = MAG_W'(a_m_reg[2][1]) + MAG_W'(a_m_reg[1][2]);
                    n[2] = MAG_W'(a_m_reg[0][1]) - MAG_W'(a_m_reg[1][0]);
                end
                default:
                begin
                    rad_next      = e00 - e11 - e22 + one_r;
                    side_next.sel = SLOT_X;
                    n[0] = MAG_W'(a_m_reg[0][1]) + MAG_W'(a_m_reg[1][0]);
                    n[1] = MAG_W'(a_m_reg[0][2]) + MAG_W'(a_m_reg[2][0]);
                    n[2] = MAG_W'(a_m_reg[1][2]) - MAG_W'(a_m_reg[2][1]);
                end
            endcase
        end
        // radicand never below one lsb
        if (rad_next < 1)
        begin
            rad_next = (RAD_W+1)'(1);
        end
        for (int l = 0; l < 3; l++)
        begin
            side_next.neg[l] = n[l] < 0;
            side_next.mag[l] = mag_of(n[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_rad_reg  <= rad_next[RAD_W-1:0];
            b_side_reg <= side_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign rad       = b_rad_reg;
    assign side      = b_side_reg;

endmodule

`default_nettype wire

// File: design/rmq_isqrt.sv
// pipelined integer square root, one root bit per stage
// depends on rmq_pkg
`default_nettype none

module rmq_isqrt
    import rmq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [RAD_W-1:0]    rad,
    input  rmq_side_t           side_in,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   root,
    output rmq_side_t           side_out
);

    localparam int REM_W = ROOT_W + 1;

    logic              st_valid_reg [ROOT_W];
    logic [XW-1:0]     st_x_reg     [ROOT_W];
    logic [REM_W-1:0]  st_rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] st_r_reg     [ROOT_W];
    rmq_side_t         st_side_reg  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_st
        logic              pv;
        logic [XW-1:0]     px;
        logic [REM_W-1:0]  prem;
        logic [ROOT_W-1:0] pr;
        rmq_side_t         ps;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic              ge;
        logic [REM_W+1:0]  rem_diff;

        if (k == 0)
        begin : g_first
            assign pv   = in_valid;
            assign px   = XW'(rad) << FRAC_BITS;
            assign prem = '0;
            assign pr   = '0;
            assign ps   = side_in;
        end
        else
        begin : g_next
            assign pv   = st_valid_reg[k-1];
            assign px   = st_x_reg[k-1];
            assign prem = st_rem_reg[k-1];
            assign pr   = st_r_reg[k-1];
            assign ps   = st_side_reg[k-1];
        end

        assign rem_sh   = {prem, px[XW-1 -: 2]};
        assign trial    = {1'b0, pr, 2'b01};
        assign ge       = rem_sh >= trial;
        assign rem_diff = rem_sh - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                st_valid_reg[k] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_x_reg[k]    <= px << 2;
                st_rem_reg[k]  <= ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                st_r_reg[k]    <= {pr[ROOT_W-2:0], ge};
                st_side_reg[k] <= ps;
            end
        end
    end

    assign out_valid = st_valid_reg[ROOT_W-1];
    assign root      = st_r_reg[ROOT_W-1];
    assign side_out  = st_side_reg[ROOT_W-1];

endmodule

`default_nettype wire

// File: design/rmq_div.sv
// three-lane pipelined restoring divider, one quotient bit per stage
// depends on rmq_pkg
`default_nettype none

module rmq_div
    import rmq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [ROOT_W-1:0]   root,
    input  rmq_side_t           side_in,
    output logic                out_valid,
    output rmq_quo_t            quo
);

    logic [DEN_W-1:0]            den;
    logic [2:0][DREM_W-1:0]      rem0;
    logic [2:0][QUO_W-1:0]       dl0;
    logic [2:0]                  sat0;
    rmq_qside_t                  qs0;

    // entry stage
    logic                        e_valid_reg;
    logic [DEN_W-1:0]            e_den_reg;
    logic [2:0][DREM_W-1:0]      e_rem_reg;
    logic [2:0][QUO_W-1:0]       e_dl_reg;
    logic [2:0]                  e_sat_reg;
    rmq_qside_t                  e_side_reg;

    // quotient bit stages
    logic                        st_valid_reg [QUO_W];
    logic [DEN_W-1:0]            st_den_reg   [QUO_W];
    logic [2:0][DREM_W-1:0]      st_rem_reg   [QUO_W];
    logic [2:0][QUO_W-1:0]       st_dl_reg    [QUO_W];
    logic [2:0][QUO_W-1:0]       st_q_reg     [QUO_W];
    logic [2:0]                  st_sat_reg   [QUO_W];
    rmq_qside_t                  st_side_reg  [QUO_W];

    assign den = {root, 1'b0};

    always_comb
    begin
        logic [DVD_W-1:0] dvd;
        qs0.degen = side_in.degen;
        qs0.sel   = side_in.sel;
        qs0.neg   = side_in.neg;
        qs0.half  = root[ROOT_W-1:1];
        for (int l = 0; l < 3; l++)
        begin
            dvd     = DVD_W'(side_in.mag[l]) << FRAC_BITS;
            rem0[l] = DREM_W'(dvd >> QUO_W);
            dl0[l]  = dvd[QUO_W-1:0];
            // quotient would reach 2^QUO_W
            sat0[l] = CMP_W'(side_in.mag[l]) >= (CMP_W'(den) << SAT_SH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_den_reg  <= den;
            e_rem_reg  <= rem0;
            e_dl_reg   <= dl0;
            e_sat_reg  <= sat0;
            e_side_reg <= qs0;
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_st
        logic                   pv;
        logic [DEN_W-1:0]       pden;
        logic [2:0][DREM_W-1:0] prem;
        logic [2:0][QUO_W-1:0]  pdl;
        logic [2:0][QUO_W-1:0]  pq;
        logic [2:0]             psat;
        rmq_qside_t             ps;
        logic [2:0][DREM_W-1:0] rem_next;
        logic [2:0][QUO_W-1:0]  q_next;

        if (k == 0)
        begin : g_first
            assign pv   = e_valid_reg;
            assign pden = e_den_reg;
            assign prem = e_rem_reg;
            assign pdl  = e_dl_reg;
            assign pq   = '0;
            assign psat = e_sat_reg;
            assign ps   = e_side_reg;
        end
        else
        begin : g_next
            assign pv   = st_valid_reg[k-1];
            assign pden = st_den_reg[k-1];
            assign prem = st_rem_reg[k-1];
            assign pdl  = st_dl_reg[k-1];
            assign pq   = st_q_reg[k-1];
            assign psat = st_sat_reg[k-1];
            assign ps   = st_side_reg[k-1];
        end

        always_comb
        begin
            logic [DREM_W-1:0] sh;
            logic              ge;
            for (int l = 0; l < 3; l++)
            begin
                sh          = {prem[l][DREM_W-2:0], pdl[l][QUO_W-1]};
                ge          = sh >= {1'b0, pden};
                rem_next[l] = ge ? sh - {1'b0, pden} : sh;
                q_next[l]   = {pq[l][QUO_W-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                st_valid_reg[k] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_den_reg[k]  <= pden;
                st_rem_reg[k]  <= rem_next;
                st_dl_reg[k]   <= pdl << 1;
                st_q_reg[k]    <= q_next;
                st_sat_reg[k]  <= psat;
                st_side_reg[k] <= ps;
            end
        end
    end

    assign out_valid = st_valid_reg[QUO_W-1];
    assign quo.side  = st_side_reg[QUO_W-1];
    assign quo.sat   = st_sat_reg[QUO_W-1];
    assign quo.quo   = st_q_reg[QUO_W-1];

endmodule

`default_nettype wire

// File: design/rotation_matrix_to_quaternion.sv
// top level: rotation matrix to unit quaternion, apb register and output stage
// depends on rmq_pkg, rmq_front, rmq_isqrt, rmq_div and the macros header
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------------------
//  matrix    | mat_valid / mat_ready | mat  (rmq_in_t, m00..m23 Q16.16)
//  quat      | quat_valid/quat_ready | quat (rmq_out_t, x y z w, degenerate)
//  config    | psel penable pwrite   | paddr, pwdata, prdata (zero_threshold)
//
// one matrix taken per cycle unless stalled; 2 front stages, ROOT_W square root
// stages, 1 + QUO_W divider stages and the output register (Q16.16 sizing)
// the depth is set by the bit-per-stage square root and the three dividers
// rst_n clears all valid bits and sets zero_threshold to 1
// a stalled output holds the whole pipeline only once its last stage is full
`default_nettype none

`include "rotation_matrix_to_quaternion_macros.svh"

module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,

    input  logic                mat_valid,
    output logic                mat_ready,
    input  rmq_in_t             mat,

    output logic                quat_valid,
    input  logic                quat_ready,
    output rmq_out_t            quat
);

    logic [ZT_W-1:0]    zt_reg;

    logic               adv;
    logic               out_take;

    logic               fr_valid;
    logic [RAD_W-1:0]   fr_rad;
    rmq_side_t          fr_side;

    logic               sq_valid;
    logic [ROOT_W-1:0]  sq_root;
    rmq_side_t          sq_side;

    logic               dv_valid;
    rmq_quo_t           dv_quo;

    logic               quat_valid_reg;
    logic               quat_valid_next;
    rmq_out_t           quat_reg;
    rmq_out_t           quat_next;

    // ---------------------------------------------------------------- apb
    assign pready = 1'b1;
    assign prdata = (paddr == ZT_ADDR) ? PDATA_W'(zt_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zt_reg <= ZT_W'(1);
        end
        else if (psel && penable && pwrite && pready && (paddr == ZT_ADDR))
        begin
            zt_reg <= pwdata[ZT_W-1:0];
        end
    end

    // ---------------------------------------------------------------- flow
    // the pipeline moves as one; it may move while the output register waits
    // as long as the divider's last stage holds no transfer
    assign out_take  = !quat_valid_reg || quat_ready;
    assign adv       = !dv_valid || out_take;
    assign mat_ready = adv;

    // ---------------------------------------------------------------- datapath
    rmq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (mat_valid),
        .mat       (mat),
        .zero_thr  (zt_reg),
        .out_valid (fr_valid),
        .rad       (fr_rad),
        .side      (fr_side)
    );

    rmq_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .rad       (fr_rad),
        .side_in   (fr_side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    rmq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .root      (sq_root),
        .side_in   (sq_side),
        .out_valid (dv_valid),
        .quo       (dv_quo)
    );

    // ---------------------------------------------------------------- output
    // each divider lane: saturate, then restore the numerator's sign
    always_comb
    begin
        logic signed [DATA_W-1:0] lane [3];
        logic signed [DATA_W-1:0] half;
        logic signed [DATA_W-1:0] pos;
        logic [1:0]               sel;
        for (int l = 0; l < 3; l++)
        begin
            pos = DATA_W'(dv_quo.quo[l]);
            if (dv_quo.sat[l])
            begin
                lane[l] = dv_quo.side.neg[l] ? {1'b1, {(DATA_W-1){1'b0}}}
                                             : {1'b0, {(DATA_W-1){1'b1}}};
            end
            else
            begin
                lane[l] = dv_quo.side.neg[l] ? -pos : pos;
            end
        end
        half = DATA_W'(dv_quo.side.half);
        sel  = dv_quo.side.sel;

        // the axis slot gets r/2, the other slots take the lanes in order
        quat_next.quat_x = (sel == SLOT_X) ? half : lane[0];
        quat_next.quat_y = (sel == SLOT_Y) ? half : ((sel == SLOT_X) ? lane[0] : lane[1]);
        quat_next.quat_z = (sel == SLOT_Z) ? half :
                           ((sel == SLOT_W) ? lane[2] : lane[1]);
        quat_next.quat_w = (sel == SLOT_W) ? half : lane[2];
        quat_next.degenerate = 1'b0;

        // nearly zero row: identity
        if (dv_quo.side.degen)
        begin
            quat_next.quat_x     = '0;
            quat_next.quat_y     = '0;
            quat_next.quat_z     = '0;
            quat_next.quat_w     = DATA_W'(ONE);
            quat_next.degenerate = 1'b1;
        end
    end

    assign quat_valid_next = out_take ? dv_valid : quat_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_valid_reg <= 1'b0;
        end
        else
        begin
            quat_valid_reg <= quat_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && dv_valid)
        begin
            quat_reg <= quat_next;
        end
    end

    assign quat_valid = quat_valid_reg;
    assign quat       = quat_reg;

    // ---------------------------------------------------------------- checks
    `RMQ_ASSERT_NOW(a_stall_only_when_full, !mat_ready, quat_valid && !quat_ready)
    `RMQ_ASSERT_NOW(a_degenerate_identity, quat_valid && quat.degenerate, quat.quat_x == '0 && quat.quat_y == '0 && quat.quat_z == '0 && quat.quat_w == DATA_W'(ONE))
    `RMQ_ASSERT_NEXT(a_threshold_write, psel && penable && pwrite && paddr == ZT_ADDR, zt_reg == $past(pwdata[ZT_W-1:0]))

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench for rotation_matrix_to_quaternion: directed and random matrices
// checked against a behavioral quaternion predictor; uses rmq_pkg and the rtl

module tb_top;
    import rmq_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                mat_valid;
    logic                mat_ready;
    rmq_in_t             mat;
    logic                quat_valid;
    logic                quat_ready;
    rmq_out_t            quat;

    rotation_matrix_to_quaternion DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .mat_valid  (mat_valid),
        .mat_ready  (mat_ready),
        .mat        (mat),
        .quat_valid (quat_valid),
        .quat_ready (quat_ready),
        .quat       (quat)
    );

    // matrices waiting to be offered, and quaternions waiting to come out
    rmq_in_t    mat_queue[$];
    rmq_out_t   quat_expected[$];

    // predictor copy of the threshold register
    logic [ZT_W-1:0] zero_thr;

    int     mismatches;
    int     mats_sent;
    int     quats_seen;
    int     degen_seen;
    int     send_gap;
    int     recv_gap;
    bit     no_idle;
    logic   hold_off;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // integer square root, one bit pair per pass
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // signed numerator over unsigned denominator, fraction bits kept
    function automatic longint fixed_div(input longint num, input longint unsigned den);
        bit neg;
        longint unsigned mag;
        longint unsigned qv;
        neg = num < 0;
        mag = neg ? longint'(-num) : num;
        qv = (mag << FRAC_BITS) / den;
        if (qv > 64'h8000_0000)
            qv = 64'h8000_0000;
        return clamp32(neg ? -longint'(qv) : longint'(qv));
    endfunction

    function automatic rmq_out_t quat_of(input rmq_in_t a, input logic [ZT_W-1:0] thr);
        longint m[3][4];
        longint q[4];
        longint one;
        longint tr;
        longint rad;
        longint av;
        longint unsigned root;
        longint unsigned den;
        bit degen;
        bit row_small;
        int i;
        int j;
        int k;
        rmq_out_t o;
        one = longint'(1) << FRAC_BITS;
        m[0][0] = a.m00; m[0][1] = a.m01; m[0][2] = a.m02; m[0][3] = a.m03;
        m[1][0] = a.m10; m[1][1] = a.m11; m[1][2] = a.m12; m[1][3] = a.m13;
        m[2][0] = a.m20; m[2][1] = a.m21; m[2][2] = a.m22; m[2][3] = a.m23;
        degen = 0;
        for (int r = 0; r < 3; r++) begin
            row_small = 1;
            for (int c = 0; c < 4; c++) begin
                av = (m[r][c] < 0) ? -m[r][c] : m[r][c];
                if (av > longint'(thr))
                    row_small = 0;
            end
            if (row_small)
                degen = 1;
        end
        if (degen) begin
            q[0] = 0; q[1] = 0; q[2] = 0; q[3] = one;
        end
        else begin
            tr = m[0][0] + m[1][1] + m[2][2];
            if (tr > 0) begin
                rad  = tr + one;
                root = int_sqrt(longint'(rad) << FRAC_BITS);
                den  = root * 2;
                q[3] = clamp32(longint'(root >> 1));
                q[0] = fixed_div(m[1][2] - m[2][1], den);
                q[1] = fixed_div(m[2][0] - m[0][2], den);
                q[2] = fixed_div(m[0][1] - m[1][0], den);
            end
            else begin
                // largest diagonal picks the axis, the other two follow cyclically
                i = 0;
                if (m[1][1] > m[0][0])
                    i = 1;
                if (m[2][2] > m[i][i])
                    i = 2;
                j = (i + 1) % 3;
                k = (j + 1) % 3;
                rad = m[i][i] - m[j][j] - m[k][k] + one;
                if (rad < 1)
                    rad = 1;
                root = int_sqrt(longint'(rad) << FRAC_BITS);
                den  = root * 2;
                q[i] = clamp32(longint'(root >> 1));
                q[3] = fixed_div(m[j][k] - m[k][j], den);
                q[j] = fixed_div(m[i][j] + m[j][i], den);
                q[k] = fixed_div(m[i][k] + m[k][i], den);
            end
        end
        o.quat_x     = 32'(q[0]);
        o.quat_y     = 32'(q[1]);
        o.quat_z     = 32'(q[2]);
        o.quat_w     = 32'(q[3]);
        o.degenerate = degen;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // clock, reset, watchdog
    // ------------------------------------------------------------------

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // generous bound: every item at its worst gap plus stall, the hold-off and drains
    initial
    begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // matrix driver: offers queued matrices, random gaps between transfers
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_valid <= 1'b0;
            send_gap  <= 0;
        end
        else
        begin
            // prediction at the accepting edge; the threshold only moves while idle
            if (mat_valid && mat_ready)
            begin
                quat_expected.push_back(quat_of(mat, zero_thr));
                mats_sent <= mats_sent + 1;
            end
            if (mat_valid && !mat_ready)
                ;   // hold payload until the transfer happens
            else if (send_gap != 0)
            begin
                mat_valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end
            else if (mat_queue.size() != 0)
            begin
                mat       <= mat_queue.pop_front();
                mat_valid <= 1'b1;
                send_gap  <= no_idle ? 0 : $urandom_range(0, 19);
            end
            else
                mat_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // quaternion monitor: random stalls, compares against oldest expectation
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        int g;
        rmq_out_t e;
        if (!rst_n)
        begin
            quat_ready <= 1'b0;
            recv_gap   <= 0;
        end
        else
        begin
            g = recv_gap;
            if (quat_valid && quat_ready)
            begin
                quats_seen <= quats_seen + 1;
                if (quat_expected.size() == 0)
                begin
                    $display("%0t: unexpected quaternion transfer, actual %h", $time, quat);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    e = quat_expected.pop_front();
                    if (e.degenerate)
                        degen_seen <= degen_seen + 1;
                    if (quat.quat_x !== e.quat_x)
                        $display("%0t: quat_x expected %h actual %h", $time, e.quat_x,
                                 quat.quat_x);
                    if (quat.quat_y !== e.quat_y)
                        $display("%0t: quat_y expected %h actual %h", $time, e.quat_y,
                                 quat.quat_y);
                    if (quat.quat_z !== e.quat_z)
                        $display("%0t: quat_z expected %h actual %h", $time, e.quat_z,
                                 quat.quat_z);
                    if (quat.quat_w !== e.quat_w)
                        $display("%0t: quat_w expected %h actual %h", $time, e.quat_w,
                                 quat.quat_w);
                    if (quat.degenerate !== e.degenerate)
                        $display("%0t: degenerate expected %b actual %b", $time,
                                 e.degenerate, quat.degenerate);
                    if (quat !== e)
                        mismatches <= mismatches + 1;
                end
                g = no_idle ? 0 : $urandom_range(0, 19);
            end
            if (hold_off)
                quat_ready <= 1'b0;
            else if (g != 0)
            begin
                quat_ready <= 1'b0;
                g = g - 1;
            end
            else
                quat_ready <= 1'b1;
            recv_gap <= g;
        end
    end

    // long receiver hold-off during the back-to-back phase so the pipeline
    // fills and backs up into mat_ready
    initial
    begin
        hold_off = 1'b0;
        wait (no_idle);
        repeat (20) @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic rmq_in_t mat_of(input int a00, a01, a02, a03, a10, a11, a12, a13,
                                       input int a20, a21, a22, a23);
        rmq_in_t t;
        t = {a00, a01, a02, a03, a10, a11, a12, a13, a20, a21, a22, a23};
        return t;
    endfunction

    function automatic int near_unit();
        return $urandom_range(0, 2 * ONE) - ONE;
    endfunction

    // values clustered around the threshold so rows land on both sides of it
    function automatic int near_thr(input logic [ZT_W-1:0] thr);
        int v;
        v = $urandom_range(0, int'(thr) + 2);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic rmq_in_t random_mat(input logic [ZT_W-1:0] thr);
        rmq_in_t t;
        int kind;
        int row;
        kind = $urandom_range(0, 9);
        if (kind < 5)
        begin
            // rotation-like: entries within one unit, small column 3
            t = mat_of(near_unit(), near_unit(), near_unit(), $urandom_range(0, 15),
                       near_unit(), near_unit(), near_unit(), $urandom_range(0, 15),
                       near_unit(), near_unit(), near_unit(), $urandom_range(0, 15));
        end
        else if (kind < 7)
            t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        else
        begin
            t = mat_of(near_unit(), near_unit(), near_unit(), near_unit(),
                       near_unit(), near_unit(), near_unit(), near_unit(),
                       near_unit(), near_unit(), near_unit(), near_unit());
            row = $urandom_range(0, 2);
            // one row pushed near the threshold
            if (row == 0)
                {t.m00, t.m01, t.m02, t.m03} = {near_thr(thr), near_thr(thr),
                                                near_thr(thr), near_thr(thr)};
            else if (row == 1)
                {t.m10, t.m11, t.m12, t.m13} = {near_thr(thr), near_thr(thr),
                                                near_thr(thr), near_thr(thr)};
            else
                {t.m20, t.m21, t.m22, t.m23} = {near_thr(thr), near_thr(thr),
                                                near_thr(thr), near_thr(thr)};
        end
        return t;
    endfunction

    task automatic write_threshold(input logic [ZT_W-1:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ZT_ADDR;
        pwdata  <= PDATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        zero_thr = v;
    endtask

    // drains both channels, then lets the pipeline settle before a register write
    task automatic wait_idle();
        while (mat_queue.size() != 0 || mat_valid || quat_expected.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        logic [ZT_W-1:0] thr_list[5];
        int mx;
        int mn;
        mismatches = 0;
        mats_sent  = 0;
        quats_seen = 0;
        degen_seen = 0;
        no_idle    = 0;
        zero_thr   = 1;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        mat        = '0;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed set at the reset threshold
        mat_queue.push_back(mat_of(ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0));
        // half turns about x, y and z: each axis chosen by the non-positive trace path
        mat_queue.push_back(mat_of(ONE, 0, 0, 0, 0, -ONE, 0, 0, 0, 0, -ONE, 0));
        mat_queue.push_back(mat_of(-ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, -ONE, 0));
        mat_queue.push_back(mat_of(-ONE, 0, 0, 0, 0, -ONE, 0, 0, 0, 0, ONE, 0));
        // quarter turn about z
        mat_queue.push_back(mat_of(0, ONE, 0, 0, -ONE, 0, 0, 0, 0, 0, ONE, 0));
        // nearly zero rows, one each, and one just above the threshold
        mat_queue.push_back(mat_of(0, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0));
        mat_queue.push_back(mat_of(ONE, 0, 0, 0, 1, -1, 1, -1, 0, 0, ONE, 0));
        mat_queue.push_back(mat_of(ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 1));
        mat_queue.push_back(mat_of(ONE, 0, 0, 0, 0, ONE, 0, 0, 2, 0, 0, 0));
        // column 3 alone keeps a row from being nearly zero
        mat_queue.push_back(mat_of(0, 0, 0, mn, 0, ONE, 0, 0, 0, 0, ONE, 0));
        // field extremes and saturation
        mat_queue.push_back(mat_of(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
        mat_queue.push_back(mat_of(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
        mat_queue.push_back(mat_of(mx, mn, mx, mn, mn, mx, mn, mx, mx, mn, mx, mn));
        mat_queue.push_back(mat_of(mn, mx, mn, 0, mx, mn, mx, 0, mn, mx, mn, 0));
        mat_queue.push_back(mat_of(0, mx, mx, 0, mx, 0, mx, 0, mn, mn, 0, 0));
        // trace exactly zero and one lsb above, ties on the diagonal
        mat_queue.push_back(mat_of(0, 5, 7, 0, 9, 0, 3, 0, 4, 6, 0, 0));
        mat_queue.push_back(mat_of(1, 5, 7, 0, 9, 0, 3, 0, 4, 6, 0, 0));
        mat_queue.push_back(mat_of(-ONE, 3, 0, 0, 0, -ONE, 8, 0, 2, 0, -ONE, 0));
        mat_queue.push_back(mat_of(mn, 0, 0, 0, 0, mn, 0, 0, 0, 0, mn, 9));
        mat_queue.push_back(mat_of(mx, 1, 2, 3, 4, mn, 5, 6, 7, 8, mn, 9));

        // thresholds per phase: reset value, none, widest, random, back to one
        thr_list[0] = 16'd1;
        thr_list[1] = 16'd0;
        thr_list[2] = 16'hffff;
        thr_list[3] = 16'($urandom_range(2, 65534));
        thr_list[4] = 16'd1;
        for (int p = 0; p < 5; p++)
        begin
            if (p != 0)
            begin
                wait_idle();
                write_threshold(thr_list[p]);
            end
            // back-to-back stretch in one phase, idling elsewhere
            no_idle = (p == 2);
            for (int n = 0; n < 226; n++)
                mat_queue.push_back(random_mat(zero_thr));
        end
        wait_idle();

        $display("covered %0d matrices, %0d quaternions checked, %0d degenerate",
                 mats_sent, quats_seen, degen_seen);
        $display("threshold settings 1, 0, 65535, %0d and 1 again", thr_list[3]);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
